>>> hdl/rkg_pkg.sv
// shared types and constants for the rsa key pair generator
`timescale 1ns / 1ps
`default_nettype none
package rkg_pkg;

  localparam int unsigned PRIME_LIMIT_DEF = 256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_GCD,
    ST_REDUCE,
    ST_INV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;      // latch the primes of an accepted beat
    logic load;         // form modulus, totient and range check
    logic gcd_first;    // start the exponent search at two
    logic gcd_next;     // move to the next exponent candidate
    logic gcd_step;     // one binary gcd step
    logic reduce_init;  // copy the exponent into the stride register
    logic reduce_step;  // subtract the totient from the stride
    logic inv_init;     // start the inverse search
    logic inv_step;     // advance the inverse candidate
    logic finish;       // write a good key to the result registers
    logic fail;         // write the error result
  } cmd_t;

  typedef struct packed {
    logic key_bad;
    logic gcd_even;
    logic gcd_eq;
    logic gcd_one;
    logic step_big;
    logic inv_hit;
  } status_t;

endpackage
`default_nettype wire

>>> hdl/rkg_datapath.sv
// datapath: products, binary gcd, modular stride and inverse search
`timescale 1ns / 1ps
`default_nettype none
module rkg_datapath #(
  parameter int unsigned PRIME_LIMIT = rkg_pkg::PRIME_LIMIT_DEF
) (
  input  wire logic           clk,
  input  wire logic [7:0]     prime_p,
  input  wire logic [7:0]     prime_q,
  input  wire rkg_pkg::cmd_t  cmd,
  output rkg_pkg::status_t    status,
  output logic [15:0]         modulus,
  output logic [15:0]         public_exp,
  output logic [15:0]         private_exp,
  output logic                key_error
);
  import rkg_pkg::*;

  localparam logic [16:0] LIMIT = 17'(PRIME_LIMIT);

  logic [7:0]  p_r, q_r;
  logic [15:0] n, phi;
  logic        bad;
  logic [15:0] e;
  logic [15:0] ga, gb;
  logic        odd_ok;
  logic [15:0] step;
  logic [15:0] r;
  logic [15:0] d;

  logic [15:0] phi_prod;
  logic        range_bad;
  logic [15:0] e_cand;
  logic [16:0] r_sum;
  logic [15:0] r_next;

  always_comb begin
    phi_prod  = {8'd0, p_r - 8'd1} * {8'd0, q_r - 8'd1};
    range_bad = (p_r < 8'd2) || (q_r < 8'd2) ||
                ({9'd0, p_r} >= LIMIT) || ({9'd0, q_r} >= LIMIT);
    e_cand    = cmd.gcd_first ? 16'd2 : e + 16'd1;
    // both operands below phi, so one conditional subtract reduces the sum
    r_sum     = {1'b0, r} + {1'b0, step};
    r_next    = (r_sum >= {1'b0, phi}) ? 16'(r_sum - {1'b0, phi}) : r_sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      p_r <= prime_p;
      q_r <= prime_q;
    end
    if (cmd.load) begin
      n   <= {8'd0, p_r} * {8'd0, q_r};
      phi <= phi_prod;
      bad <= range_bad || (phi_prod < 16'd2);
    end
    if (cmd.gcd_first || cmd.gcd_next) begin
      e      <= e_cand;
      ga     <= e_cand;
      gb     <= phi;
      odd_ok <= e_cand[0] | phi[0];
    end else if (cmd.gcd_step) begin
      if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga > gb) begin
        ga <= ga - gb;
      end else begin
        gb <= gb - ga;
      end
    end
    if (cmd.reduce_init) begin
      step <= e;
    end else if (cmd.reduce_step) begin
      step <= step - phi;
    end
    if (cmd.inv_init) begin
      r <= step;
      d <= 16'd1;
    end else if (cmd.inv_step) begin
      r <= r_next;
      d <= d + 16'd1;
    end
    if (cmd.finish) begin
      modulus     <= n;
      public_exp  <= e;
      private_exp <= d;
      key_error   <= 1'b0;
    end else if (cmd.fail) begin
      modulus     <= 16'd0;
      public_exp  <= 16'd0;
      private_exp <= 16'd0;
      key_error   <= 1'b1;
    end
  end

  always_comb begin
    status.key_bad  = bad;
    status.gcd_even = !odd_ok;
    status.gcd_eq   = (ga == gb);
    status.gcd_one  = (ga == 16'd1);
    status.step_big = (step >= phi);
    status.inv_hit  = (r == 16'd1) && (d != 16'd1);
  end

endmodule
`default_nettype wire

>>> hdl/rkg_ctrl.sv
// controller state machine sequencing the key search
`timescale 1ns / 1ps
`default_nettype none
module rkg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire rkg_pkg::status_t  status,
  output rkg_pkg::cmd_t          cmd,
  output logic                   busy,
  output logic                   done
);
  import rkg_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.key_bad) begin
          cmd.fail   = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.gcd_first = 1'b1;
          state_next    = ST_GCD;
        end
      end
      ST_GCD: begin
        // a common factor two or an odd gcd above one rejects the candidate
        if (status.gcd_even || (status.gcd_eq && !status.gcd_one)) begin
          cmd.gcd_next = 1'b1;
        end else if (status.gcd_eq) begin
          cmd.reduce_init = 1'b1;
          state_next      = ST_REDUCE;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_REDUCE: begin
        if (status.step_big) begin
          cmd.reduce_step = 1'b1;
        end else begin
          cmd.inv_init = 1'b1;
          state_next   = ST_INV;
        end
      end
      ST_INV: begin
        if (status.inv_hit) begin
          cmd.finish = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.inv_step = 1'b1;
        end
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/rsa_key_pair_generator.sv
// top level of the small rsa key pair generator
//
// usage: drive prime_p and prime_q and raise start; the beat is taken at a
// rising edge with start high and busy low. busy stays high through the result
// beat, which sits on modulus, public_exp, private_exp and key_error for one
// cycle marked by done. the receiver cannot stall, so the result must be
// taken in that cycle; the result registers then hold until the next beat.
// the work runs as setup (capture, load and range check), the public exponent
// search (a binary gcd per candidate), a stride reduction of the exponent by
// the totient, and a private exponent search that tries one candidate per
// cycle; the inverse search loop dominates the total.
// one beat is in work at a time.
// factors below two, at or above the prime limit, or a totient below two
// give key_error high with zero key fields straight from the check state,
// and the next beat can be taken once the controller is back in idle.
// reset returns the controller to idle; any search in progress is dropped.
`timescale 1ns / 1ps
`default_nettype none
module rsa_key_pair_generator #(
  parameter int unsigned PRIME_LIMIT = rkg_pkg::PRIME_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  prime_p,
  input  wire logic [7:0]  prime_q,
  output logic             done,
  output logic [15:0]      modulus,
  output logic [15:0]      public_exp,
  output logic [15:0]      private_exp,
  output logic             key_error
);
  import rkg_pkg::*;

  cmd_t    cmd;
  status_t status;

  rkg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  rkg_datapath #(
    .PRIME_LIMIT (PRIME_LIMIT)
  ) u_datapath (
    .clk         (clk),
    .prime_p     (prime_p),
    .prime_q     (prime_q),
    .cmd         (cmd),
    .status      (status),
    .modulus     (modulus),
    .public_exp  (public_exp),
    .private_exp (private_exp),
    .key_error   (key_error)
  );

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && key_error) |-> (modulus == 16'd0 && public_exp == 16'd0 &&
                             private_exp == 16'd0))
    else $error("error result carries nonzero key fields");

  a_key_range: assert property (@(posedge clk) disable iff (rst)
    (done && !key_error) |-> (public_exp >= 16'd2 && private_exp >= 16'd2))
    else $error("exponent below two on a good key");

endmodule
`default_nettype wire

>>> tb/sv/rsa_key_pair_generator_tb.sv
// testbench for the rsa key pair generator: directed and random factor pairs with a key predictor
`timescale 1ns / 1ps
module rsa_key_pair_generator_tb;

  typedef struct packed {
    logic [15:0] modulus;
    logic [15:0] public_exp;
    logic [15:0] private_exp;
    logic        key_error;
  } rsa_key_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [7:0]  prime_p = '0;
  logic [7:0]  prime_q = '0;
  logic        busy;
  logic        done;
  logic [15:0] modulus;
  logic [15:0] public_exp;
  logic [15:0] private_exp;
  logic        key_error;

  rsa_key_t pending_keys[$];
  rsa_key_t want_key;
  int       err_cnt = 0;
  bit       idle_on = 1'b1;

  rsa_key_pair_generator u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .prime_p     (prime_p),
    .prime_q     (prime_q),
    .done        (done),
    .modulus     (modulus),
    .public_exp  (public_exp),
    .private_exp (private_exp),
    .key_error   (key_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned common_divisor(input int unsigned a, input int unsigned b);
    int unsigned r;
    forever begin
      r = a % b;
      if (r == 0) return b;
      a = b;
      b = r;
    end
  endfunction

  // key set for one pair of factors, error key when a factor is out of range or the totient is below two
  function automatic rsa_key_t derive_key(input logic [7:0] p, input logic [7:0] q);
    rsa_key_t    k;
    int unsigned pv, qv, tot, e, d;
    k = '0;
    k.key_error = 1'b1;
    pv = p;
    qv = q;
    if (pv < 2 || qv < 2 || pv >= rkg_pkg::PRIME_LIMIT_DEF || qv >= rkg_pkg::PRIME_LIMIT_DEF)
      return k;
    tot = (pv - 1) * (qv - 1);
    if (tot < 2) return k;
    e = 2;
    while (common_divisor(e, tot) != 1) e++;
    d = 2;
    while ((longint'(d) * longint'(e)) % longint'(tot) != 1) d++;
    k.modulus     = 16'(pv * qv);
    k.public_exp  = 16'(e);
    k.private_exp = 16'(d);
    k.key_error   = 1'b0;
    return k;
  endfunction

  function automatic bit is_prime(input int unsigned v);
    if (v < 2) return 1'b0;
    for (int unsigned f = 2; f * f <= v; f++)
      if (v % f == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_prime(input int unsigned lo, input int unsigned hi);
    int unsigned v;
    v = $urandom_range(hi, lo);
    while (!is_prime(v)) v = $urandom_range(hi, lo);
    return 8'(v);
  endfunction

  task automatic note_field(input string name, input int unsigned want, input int unsigned got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, name, want, got);
  endtask

  // result beats against the oldest predicted key
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_keys.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result beat at %0t: modulus %0d", $realtime, modulus);
      end else begin
        want_key = pending_keys.pop_front();
        if (modulus !== want_key.modulus)
          note_field("modulus", want_key.modulus, modulus);
        if (public_exp !== want_key.public_exp)
          note_field("public_exp", want_key.public_exp, public_exp);
        if (private_exp !== want_key.private_exp)
          note_field("private_exp", want_key.private_exp, private_exp);
        if (key_error !== want_key.key_error)
          note_field("key_error", want_key.key_error, key_error);
      end
    end
  end

  // one command beat; an idle burst holds start low past the point the block frees up
  task automatic send_primes(input logic [7:0] p, input logic [7:0] q);
    int gap;
    if (idle_on && $urandom_range(3, 0) == 0) begin
      gap = $urandom_range(11, 1);
      @(negedge clk);
      start <= 1'b0;
      while (busy) @(negedge clk);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    prime_p <= p;
    prime_q <= q;
    do @(posedge clk); while (busy);
    pending_keys.push_back(derive_key(p, q));
  endtask

  task automatic test_error_cases();
    send_primes(8'd2, 8'd2);
    send_primes(8'd0, 8'd0);
    send_primes(8'd1, 8'd1);
    send_primes(8'd0, 8'd255);
    send_primes(8'd255, 8'd0);
    send_primes(8'd1, 8'd5);
    send_primes(8'd5, 8'd1);
    send_primes(8'd2, 8'd1);
  endtask

  task automatic test_edge_keys();
    send_primes(8'd2, 8'd3);
    send_primes(8'd3, 8'd2);
    send_primes(8'd3, 8'd3);
    send_primes(8'd7, 8'd7);
    // composite factors go through the same arithmetic
    send_primes(8'd4, 8'd9);
    send_primes(8'd8, 8'd15);
    send_primes(8'd17, 8'd11);
    send_primes(8'd61, 8'd53);
    send_primes(8'd128, 8'd127);
    send_primes(8'd85, 8'd170);
    send_primes(8'd2, 8'd251);
    send_primes(8'd251, 8'd241);
    send_primes(8'd255, 8'd255);
  endtask

  // mostly small distinct primes, a few large ones, some arbitrary values
  task automatic test_random_keys(input int count);
    int          kind;
    logic [7:0]  p, q;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99, 0);
      if (kind < 80) begin
        p = pick_prime(2, 47);
        q = pick_prime(2, 47);
        while (q == p) q = pick_prime(2, 47);
      end else if (kind < 88) begin
        p = 8'($urandom_range(47, 0));
        q = 8'($urandom_range(47, 0));
      end else if (kind < 94) begin
        p = pick_prime(2, 255);
        q = pick_prime(2, 255);
      end else begin
        p = 8'($urandom_range(255, 0));
        q = 8'($urandom_range(255, 0));
      end
      send_primes(p, q);
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    test_random_keys(20);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_error_cases();
    test_edge_keys();
    test_random_keys(60);
    test_back_to_back();
    @(negedge clk);
    start <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #500_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
